// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/toq_pkg.sv -----
// types and constants of the time ordered event queue
package toq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int HC_W     = 7;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic        [30:0] event_time;
    logic        [7:0]  event_kind;
    logic signed [31:0] first_datum;
    logic signed [31:0] second_datum;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [30:0] out_time;
    logic        [7:0]  out_kind;
    logic signed [31:0] out_first;
    logic signed [31:0] out_second;
    logic               is_empty;
    logic        [6:0]  held_count;
  } out_item_t;

  typedef struct packed {
    logic        [30:0] ev_time;
    logic        [7:0]  ev_kind;
    logic signed [31:0] ev_first;
    logic signed [31:0] ev_second;
  } event_t;

  // broadcast to every cell
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [CNT_W-1:0] count;
    event_t          ev;
  } cell_ctl_t;

endpackage

// ----- rtl/core/toq_cell.sv -----
// one slot of the sorted shift-register queue
module toq_cell (
  input  logic               clk,
  input  logic [toq_pkg::CNT_W-1:0] idx,
  input  toq_pkg::cell_ctl_t ctl,
  input  logic               left_le,
  input  toq_pkg::event_t    left_q,
  input  toq_pkg::event_t    right_q,
  output logic               le,
  output toq_pkg::event_t    q
);
  import toq_pkg::*;

  logic occupied;

  assign occupied = idx < ctl.count;
  // this slot stays put on insert: it holds an event not later than the new one
  assign le = occupied && (q.ev_time <= ctl.ev.ev_time);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (!le) begin
        if (left_le) begin
          q <= ctl.ev;
        end else begin
          q <= left_q;
        end
      end
    end else if (ctl.rem) begin
      q <= right_q;
    end
  end

endmodule

// ----- rtl/core/time_ordered_event_queue.sv -----
// top level of the time ordered event queue
//
//  channel | direction | payload     | handshake
//  cmd     | in        | in_item_t   | cmd_valid / cmd_stall
//  res     | out       | out_item_t  | res_valid / res_stall
//
// one item per cycle while cmd_stall is low; its result sits in the output register the cycle after
// every slot compares its own time with the new one, so an insert or a removal
// is one shift of the cell row, whatever the fill level
// reset clears the entry count and the result valid flag; slots need no clearing
// cmd_stall is raised only while a result is held by res_stall
module time_ordered_event_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  toq_pkg::in_item_t  cmd_item,
  output logic               res_valid,
  input  logic               res_stall,
  output toq_pkg::out_item_t res_item
);
  import toq_pkg::*;

  logic             accept;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W+HC_W-1:0] count_wide;
  cell_ctl_t        ctl;
  event_t           head_ev;
  out_item_t        res_next;

  event_t cell_q  [CAPACITY];
  logic   cell_le [CAPACITY];

  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;

  assign full  = count == CNT_W'(CAPACITY);
  assign empty = count == '0;

  always_comb begin
    ctl.ins   = accept && (cmd_item.cmd == CMD_INSERT) && !full;
    ctl.rem   = accept && (cmd_item.cmd == CMD_REMOVE) && !empty;
    ctl.count = count;
    ctl.ev.ev_time   = cmd_item.event_time;
    ctl.ev.ev_kind   = cmd_item.event_kind;
    ctl.ev.ev_first  = cmd_item.first_datum;
    ctl.ev.ev_second = cmd_item.second_datum;
  end

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
        toq_cell u_cell (
          .clk     (clk),
          .idx     (CNT_W'(g)),
          .ctl     (ctl),
          .left_le (1'b1),
          .left_q  (ctl.ev),
          .right_q (cell_q[g+1]),
          .le      (cell_le[g]),
          .q       (cell_q[g])
        );
      end else if (g == CAPACITY - 1) begin : g_tail
        toq_cell u_cell (
          .clk     (clk),
          .idx     (CNT_W'(g)),
          .ctl     (ctl),
          .left_le (cell_le[g-1]),
          .left_q  (cell_q[g-1]),
          .right_q (cell_q[g]),
          .le      (cell_le[g]),
          .q       (cell_q[g])
        );
      end else begin : g_mid
        toq_cell u_cell (
          .clk     (clk),
          .idx     (CNT_W'(g)),
          .ctl     (ctl),
          .left_le (cell_le[g-1]),
          .left_q  (cell_q[g-1]),
          .right_q (cell_q[g+1]),
          .le      (cell_le[g]),
          .q       (cell_q[g])
        );
      end
    end
  endgenerate

  assign head_ev = ctl.rem ? cell_q[0] : '0;

  assign count_wide = {{HC_W{1'b0}}, count_next};

  always_comb begin
    res_next.status = ST_DONE;
    if (cmd_item.cmd == CMD_INSERT) begin
      if (full) begin
        res_next.status = ST_FULL;
      end
    end else if (empty) begin
      res_next.status = ST_EMPTY;
    end
    res_next.out_time   = head_ev.ev_time;
    res_next.out_kind   = head_ev.ev_kind;
    res_next.out_first  = head_ev.ev_first;
    res_next.out_second = head_ev.ev_second;
    res_next.is_empty   = count_next == '0;
    res_next.held_count = count_wide[HC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count     <= count_next;
      res_valid <= accept || (res_valid && res_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_item <= res_next;
    end
  end

  // the tail slot's compare result has no neighbour to feed
  logic unused_tail_le;
  assign unused_tail_le = cell_le[CAPACITY-1];

endmodule

// ----- rtl/core/toq_checker.sv -----
// port-level checks of the time ordered event queue, bound to the top level
`include "assert_macros.svh"

module toq_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_stall,
  input toq_pkg::in_item_t  cmd_item,
  input logic               res_valid,
  input logic               res_stall,
  input toq_pkg::out_item_t res_item
);
  import toq_pkg::*;

  logic unused_cmd_bits;
  assign unused_cmd_bits = ^cmd_item;

  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res_item), "held result item changed")
  `ASSERT_NEXT(a_res_follows, clk, rst, cmd_valid && !cmd_stall, res_valid, "accepted item gave no result")
  `ASSERT_IMPLY(a_stall_cause, clk, rst, cmd_stall, res_valid && res_stall, "input stalled without a held result")
  `ASSERT_IMPLY(a_refused_zero, clk, rst, res_valid && (res_item.status != ST_DONE), (res_item.out_time == '0) && (res_item.out_kind == '0) && !(res_item.status == ST_FULL && res_item.is_empty), "refused item carries event data")

endmodule

bind time_ordered_event_queue toq_checker u_toq_checker (.*);

// ----- bench/event_queue_checker.sv -----
// checker of the event queue: mirrors the sorted event list and compares every result item
module event_queue_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic               cmd_stall,
  input  toq_pkg::in_item_t  cmd_item,
  input  logic               res_valid,
  input  logic               res_stall,
  input  toq_pkg::out_item_t res_item,
  output int                 results_due,
  output int                 mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import toq_pkg::*;

  event_t    event_list [CAPACITY];
  int        event_count = 0;
  out_item_t awaited_results [$];
  out_item_t oldest;
  int        errors = 0;

  // applies one command to the mirrored list and returns the result it should give
  function automatic out_item_t apply_command(in_item_t c);
    out_item_t r;
    int        pos;
    int        i;
    r = '0;
    r.status = ST_DONE;
    if (c.cmd == CMD_INSERT) begin
      if (event_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // behind every queued event of equal or earlier time
        pos = 0;
        while (pos < event_count && event_list[pos].ev_time <= c.event_time) pos++;
        for (i = event_count; i > pos; i--) event_list[i] = event_list[i - 1];
        event_list[pos] = '{c.event_time, c.event_kind, c.first_datum, c.second_datum};
        event_count++;
      end
    end else if (event_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.out_time   = event_list[0].ev_time;
      r.out_kind   = event_list[0].ev_kind;
      r.out_first  = event_list[0].ev_first;
      r.out_second = event_list[0].ev_second;
      for (i = 1; i < event_count; i++) event_list[i - 1] = event_list[i];
      event_count--;
    end
    r.is_empty   = (event_count == 0);
    r.held_count = HC_W'(event_count);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      event_count = 0;
      awaited_results.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result item, expected none got %h", $time, res_item);
          errors++;
        end else begin
          oldest = awaited_results.pop_front();
          check_field("status", oldest.status, res_item.status);
          check_field("out_time", oldest.out_time, res_item.out_time);
          check_field("out_kind", oldest.out_kind, res_item.out_kind);
          check_field("out_first", oldest.out_first, res_item.out_first);
          check_field("out_second", oldest.out_second, res_item.out_second);
          check_field("is_empty", oldest.is_empty, res_item.is_empty);
          check_field("held_count", oldest.held_count, res_item.held_count);
        end
      end
      if (cmd_valid && !cmd_stall) awaited_results.push_back(apply_command(cmd_item));
    end
    results_due <= awaited_results.size();
    mismatches  <= errors;
  end

endmodule

// ----- bench/time_ordered_event_queue_test.sv -----
// top of the event queue bench: drives command items and result stalls, gives the verdict
module time_ordered_event_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import toq_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [30:0] TIME_MAX    = 31'h7FFF_FFFF;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  in_item_t  cmd_item  = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_item_t res_item;
  int        results_due;
  int        mismatches;
  int        gap_pct   = 0;
  int        hold_pct  = 0;
  int        fill      = 0;
  int        cycles    = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  time_ordered_event_queue uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  event_queue_checker check (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd_item    (cmd_item),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_item    (res_item),
    .results_due (results_due),
    .mismatches  (mismatches)
  );

  always @(posedge clk) res_stall <= ($urandom_range(99) < hold_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic op, logic [30:0] t, logic [7:0] k,
                                         logic [31:0] a, logic [31:0] b);
    in_item_t it;
    it.cmd          = op;
    it.event_time   = t;
    it.event_kind   = k;
    it.first_datum  = a;
    it.second_datum = b;
    return it;
  endfunction

  function automatic in_item_t random_item(logic op);
    logic [30:0] t;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: t = 31'($urandom_range(15));  // narrow range, plenty of ties
      5:             t = '0;
      6:             t = TIME_MAX;
      default:       t = 31'($urandom);
    endcase
    return make_item(op, t, 8'($urandom), $urandom, $urandom);
  endfunction

  task automatic send(in_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item  <= it;
    do @(posedge clk); while (cmd_stall);
    // rough fill level, only to shape the bursts
    if (it.cmd == CMD_INSERT && fill < CAPACITY) fill++;
    else if (it.cmd == CMD_REMOVE && fill > 0) fill--;
  endtask

  task automatic run_phase(int gap, int hold);
    int n;
    gap_pct  = gap;
    hold_pct = hold;
    // fill past capacity so that refused inserts occur
    n = CAPACITY - fill + 3;
    repeat (n) send(random_item(CMD_INSERT));
    repeat (30) send(random_item(($urandom_range(99) < 60) ? CMD_REMOVE : CMD_INSERT));
    // drain past empty
    n = fill + 3;
    repeat (n) send(random_item(CMD_REMOVE));
    repeat (20) send(random_item(($urandom_range(99) < 50) ? CMD_REMOVE : CMD_INSERT));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    gap_pct  = 8;
    hold_pct = 79;

    send(make_item(CMD_REMOVE, TIME_MAX, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(make_item(CMD_INSERT, TIME_MAX, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send(make_item(CMD_INSERT, '0, 8'h00, 32'h0000_0000, 32'h0000_0000));
    // equal times must leave in arrival order
    send(make_item(CMD_INSERT, 31'd5, 8'h01, 32'hFFFF_FFFF, 32'h0000_0001));
    send(make_item(CMD_INSERT, 31'd5, 8'h02, 32'h7FFF_FFFF, 32'h8000_0000));
    send(make_item(CMD_INSERT, 31'd5, 8'h03, 32'h0000_0000, 32'hFFFF_FFFF));
    send(make_item(CMD_INSERT, TIME_MAX, 8'h04, 32'h1234_5678, 32'h8765_4321));
    send(make_item(CMD_INSERT, 31'h4000_0000, 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA));
    send(make_item(CMD_INSERT, '0, 8'h55, 32'hAAAA_AAAA, 32'h5555_5555));
    repeat (10) send(make_item(CMD_REMOVE, '0, '0, '0, '0));

    run_phase(8, 79);
    run_phase(79, 8);
    run_phase(0, 0);
    cmd_valid <= 1'b0;

    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ----- time_ordered_event_queue.f -----
+incdir+rtl/core
rtl/core/toq_pkg.sv
rtl/core/toq_cell.sv
rtl/core/time_ordered_event_queue.sv
rtl/core/toq_checker.sv
bench/event_queue_checker.sv
bench/time_ordered_event_queue_test.sv
